// File: rtl/tagged_record_deframer_core_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef TAGGED_RECORD_DEFRAMER_CORE_DEFINES_SVH
`define TAGGED_RECORD_DEFRAMER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, muted while reset is asserted.
`define TRD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true at a clock edge.
`define TRD_ASSERT_NEVER(lbl, cond, msg) \
  `TRD_ASSERT(lbl, !(cond), msg)

`else

`define TRD_ASSERT(lbl, prop, msg)
`define TRD_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// File: rtl/trd_pkg.sv
// Types and constants shared by the deframer modules.
`timescale 1ns / 1ps

package trd_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned TsW    = 64;
  localparam int unsigned LenW   = 27;
  localparam int unsigned PosW   = 3;
  localparam int unsigned DigCntW = 5;

  // Most digits allowed in a number field.
  localparam logic [DigCntW-1:0] MaxDigits = DigCntW'(19);

  // Reset value of the payload length limit (64 MiB).
  localparam logic [LenW-1:0] MaxLenReset = LenW'(64 * 1024 * 1024);

  localparam logic [ByteW-1:0] ChDollar = 8'h24;
  localparam logic [ByteW-1:0] ChComma  = 8'h2C;
  localparam logic [ByteW-1:0] ChCr     = 8'h0D;
  localparam logic [ByteW-1:0] ChLf     = 8'h0A;
  localparam logic [ByteW-1:0] ChZero   = 8'h30;
  localparam logic [ByteW-1:0] ChNine   = 8'h39;

  localparam int unsigned TagLen = 6;
  localparam logic [PosW-1:0] TagLastPos = PosW'(TagLen - 1);

  // Record prefix characters, in order.
  localparam logic [ByteW-1:0] TagChars [TagLen] = '{
    8'h24, 8'h47, 8'h45, 8'h4F, 8'h44, 8'h2C
  };

  typedef enum logic [1:0] {
    EvHeader    = 2'd0,
    EvPayload   = 2'd1,
    EvMalformed = 2'd2,
    EvTruncated = 2'd3
  } event_kind_e;

  typedef struct packed {
    event_kind_e             kind;
    logic [ByteW-1:0]        payload_byte;
    logic [TsW-1:0]          timestamp_ms;
    logic [LenW-1:0]         record_length;
    logic                    last_of_record;
  } result_t;

endpackage

// File: rtl/trd_parser.sv
// Parser state and step logic: each step consumes one log item.
`timescale 1ns / 1ps
`include "tagged_record_deframer_core_defines.svh"

module trd_parser (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [trd_pkg::ByteW-1:0]   log_byte_i,
  input  logic                        end_of_log_i,
  input  logic [trd_pkg::LenW-1:0]    max_len_i,
  output logic                        res_valid_o,
  output trd_pkg::result_t            res_o
);

  typedef enum logic [2:0] {
    PhSearch  = 3'd0,
    PhStamp   = 3'd1,
    PhLength  = 3'd2,
    PhPayload = 3'd3,
    PhTerm    = 3'd4,
    PhAfterCr = 3'd5
  } phase_e;

  phase_e                         phase_q, phase_d;
  logic [trd_pkg::PosW-1:0]       pos_q, pos_d;
  logic [trd_pkg::DigCntW-1:0]    dig_cnt_q, dig_cnt_d;
  logic [trd_pkg::TsW-1:0]        acc_q, acc_d;
  logic                           ovf_q, ovf_d;
  logic [trd_pkg::TsW-1:0]        ts_q, ts_d;
  logic [trd_pkg::LenW-1:0]       total_q, total_d;
  logic [trd_pkg::LenW-1:0]       remain_q, remain_d;
  logic                           res_valid_d;
  trd_pkg::result_t               res_d;

  logic                           is_digit;
  logic [trd_pkg::TsW-1:0]        acc_next;
  logic [trd_pkg::PosW-1:0]       srch_base;
  logic [trd_pkg::PosW-1:0]       srch_pos;
  logic                           srch_hit;
  logic                           last_byte;

  assign is_digit = (log_byte_i >= trd_pkg::ChZero) && (log_byte_i <= trd_pkg::ChNine);
  // acc * 10 + digit; '0'..'9' carry their value in the low nibble
  assign acc_next = {acc_q[trd_pkg::TsW-4:0], 3'b000}
                  + {acc_q[trd_pkg::TsW-2:0], 1'b0}
                  + {{(trd_pkg::TsW-4){1'b0}}, log_byte_i[3:0]};

  // Prefix matcher: search phase continues from pos_q, a rescan starts fresh.
  assign srch_base = ((phase_q == PhSearch) && (pos_q <= trd_pkg::TagLastPos)) ? pos_q : '0;
  assign srch_hit  = (log_byte_i == trd_pkg::TagChars[srch_base]);
  assign srch_pos  = srch_hit ? (srch_base + trd_pkg::PosW'(1))
                              : ((log_byte_i == trd_pkg::ChDollar) ? trd_pkg::PosW'(1) : '0);

  assign last_byte = (remain_q <= trd_pkg::LenW'(1));

  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    dig_cnt_d   = dig_cnt_q;
    acc_d       = acc_q;
    ovf_d       = ovf_q;
    ts_d        = ts_q;
    total_d     = total_q;
    remain_d    = remain_q;
    res_valid_d = 1'b0;
    res_d       = '0;

    if (end_of_log_i) begin
      phase_d   = PhSearch;
      pos_d     = '0;
      dig_cnt_d = '0;
      acc_d     = '0;
      ovf_d     = 1'b0;
      if ((phase_q == PhStamp) || (phase_q == PhLength)) begin
        res_valid_d = 1'b1;
        res_d.kind  = trd_pkg::EvMalformed;
      end else if (phase_q == PhPayload) begin
        res_valid_d         = 1'b1;
        res_d.kind          = trd_pkg::EvTruncated;
        res_d.timestamp_ms  = ts_q;
        res_d.record_length = total_q;
      end
    end else begin
      unique case (phase_q)
        PhStamp, PhLength: begin
          if (log_byte_i == trd_pkg::ChComma) begin
            if ((dig_cnt_q == '0) || ((phase_q == PhLength) && ovf_q)) begin
              phase_d     = PhSearch;
              pos_d       = '0;
              dig_cnt_d   = '0;
              acc_d       = '0;
              ovf_d       = 1'b0;
              res_valid_d = 1'b1;
              res_d.kind  = trd_pkg::EvMalformed;
            end else if (phase_q == PhStamp) begin
              ts_d      = acc_q;
              phase_d   = PhLength;
              dig_cnt_d = '0;
              acc_d     = '0;
              ovf_d     = 1'b0;
            end else begin
              total_d   = acc_q[trd_pkg::LenW-1:0];
              remain_d  = acc_q[trd_pkg::LenW-1:0];
              dig_cnt_d = '0;
              acc_d     = '0;
              ovf_d     = 1'b0;
              pos_d     = '0;
              phase_d   = (acc_q[trd_pkg::LenW-1:0] == '0) ? PhTerm : PhPayload;
              res_valid_d          = 1'b1;
              res_d.kind           = trd_pkg::EvHeader;
              res_d.timestamp_ms   = ts_q;
              res_d.record_length  = acc_q[trd_pkg::LenW-1:0];
              res_d.last_of_record = (acc_q[trd_pkg::LenW-1:0] == '0);
            end
          end else if (!is_digit || (dig_cnt_q >= trd_pkg::MaxDigits)) begin
            phase_d     = PhSearch;
            pos_d       = '0;
            dig_cnt_d   = '0;
            acc_d       = '0;
            ovf_d       = 1'b0;
            res_valid_d = 1'b1;
            res_d.kind  = trd_pkg::EvMalformed;
          end else begin
            acc_d     = acc_next;
            dig_cnt_d = dig_cnt_q + trd_pkg::DigCntW'(1);
            if (acc_next > {{(trd_pkg::TsW-trd_pkg::LenW){1'b0}}, max_len_i}) begin
              ovf_d = 1'b1;
            end
          end
        end
        PhPayload: begin
          res_valid_d          = 1'b1;
          res_d.kind           = trd_pkg::EvPayload;
          res_d.payload_byte   = log_byte_i;
          res_d.timestamp_ms   = ts_q;
          res_d.record_length  = total_q;
          res_d.last_of_record = last_byte;
          if (last_byte) begin
            remain_d = '0;
            phase_d  = PhTerm;
          end else begin
            remain_d = remain_q - trd_pkg::LenW'(1);
          end
        end
        default: begin
          // search, terminator check, after CR, and unused codes
          if ((phase_q == PhTerm) && (log_byte_i == trd_pkg::ChCr)) begin
            phase_d = PhAfterCr;
          end else begin
            phase_d   = PhSearch;
            pos_d     = '0;
            dig_cnt_d = '0;
            acc_d     = '0;
            ovf_d     = 1'b0;
            if ((phase_q == PhSearch) || (log_byte_i != trd_pkg::ChLf)) begin
              if (srch_hit && (srch_base == trd_pkg::TagLastPos)) begin
                phase_d = PhStamp;
                pos_d   = '0;
              end else begin
                pos_d = srch_pos;
              end
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhSearch;
      pos_q       <= '0;
      dig_cnt_q   <= '0;
      acc_q       <= '0;
      ovf_q       <= 1'b0;
      ts_q        <= '0;
      total_q     <= '0;
      remain_q    <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      pos_q       <= pos_d;
      dig_cnt_q   <= dig_cnt_d;
      acc_q       <= acc_d;
      ovf_q       <= ovf_d;
      ts_q        <= ts_d;
      total_q     <= total_d;
      remain_q    <= remain_d;
    end
  end

  assign res_valid_o = step_i && res_valid_d;
  assign res_o       = res_d;

  `TRD_ASSERT_NEVER(a_payload_empty, (phase_q == PhPayload) && (remain_q == '0), "payload phase with nothing left")
  `TRD_ASSERT(a_digits_bound, dig_cnt_q <= trd_pkg::MaxDigits, "digit count beyond limit")
  `TRD_ASSERT(a_header_len, (res_valid_o && (res_d.kind == trd_pkg::EvHeader)) |=> (remain_q == total_q), "header count not loaded")

endmodule

// File: rtl/trd_out_buf.sv
// Two-entry result buffer: output register plus skid register.
`timescale 1ns / 1ps
`include "tagged_record_deframer_core_defines.svh"

module trd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  trd_pkg::result_t  push_data_i,
  input  logic              out_stall_i,
  output logic              out_valid_o,
  output trd_pkg::result_t  out_data_o,
  output logic              full_o
);

  logic             out_valid_q;
  trd_pkg::result_t out_data_q;
  logic             skid_valid_q;
  trd_pkg::result_t skid_data_q;
  logic             drain;

  assign drain = out_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      priority if (skid_valid_q) begin
        if (drain) begin
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end
      end else if (push_i) begin
        if (!out_valid_q || drain) begin
          out_valid_q <= 1'b1;
        end else begin
          skid_valid_q <= 1'b1;
        end
      end else if (drain) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // data path, no reset needed
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (drain) begin
        out_data_q <= skid_data_q;
      end
    end else if (push_i) begin
      if (!out_valid_q || drain) begin
        out_data_q <= push_data_i;
      end else begin
        skid_data_q <= push_data_i;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign full_o      = skid_valid_q;

  `TRD_ASSERT(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid holds an item ahead of output")
  `TRD_ASSERT_NEVER(a_push_full, push_i && skid_valid_q, "item pushed into full buffer")
  `TRD_ASSERT(a_skid_moves, (skid_valid_q && drain) |=> (out_valid_q && !skid_valid_q), "skid item not moved on drain")

endmodule

// File: rtl/tagged_record_deframer_core.sv
// Top level of the tagged log record deframer.
`timescale 1ns / 1ps
// Usage
//   Input channel: one log byte per item (log_byte_i), or an end-of-log mark
//   (end_of_log_i, byte ignored). Output channel: at most one event item per
//   input item: header accepted, payload byte (with last mark), malformed
//   header, or truncated record. Both channels use valid/stall; an item moves
//   at an edge with valid high and stall low.
//   Config: cfg_wr_en_i writes the payload length limit from cfg_wr_data_i;
//   write only while no item is in flight.
// Timing
//   An accepted item sits in the input register, goes through the parser into
//   the output register (or the skid register when the output register is held),
//   and its result item is then offered on the output channel.
//   Throughput is 1 item per cycle while the skid entry is free; in the parser
//   step the 64-bit multiply-by-ten add and limit compare set the critical path.
// Reset
//   Async active-low. Parser returns to prefix search, buffers empty, limit
//   back to 64 MiB.
// Stall
//   Output register plus a skid entry hold one extra result while the output is
//   stalled; input stall comes from registers only, rising once the skid is full.
`include "tagged_record_deframer_core_defines.svh"

module tagged_record_deframer_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // config
  input  logic                         cfg_wr_en_i,
  input  logic [trd_pkg::LenW-1:0]     cfg_wr_data_i,
  // input items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [trd_pkg::ByteW-1:0]    log_byte_i,
  input  logic                         end_of_log_i,
  // result items
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   event_kind_o,
  output logic [trd_pkg::ByteW-1:0]    payload_byte_o,
  output logic [trd_pkg::TsW-1:0]      timestamp_ms_o,
  output logic [trd_pkg::LenW-1:0]     record_length_o,
  output logic                         last_of_record_o
);

  logic [trd_pkg::LenW-1:0]   max_len_q;

  logic                       in_valid_q;
  logic [trd_pkg::ByteW-1:0]  in_byte_q;
  logic                       in_eol_q;

  logic                       buf_full;
  logic                       step;
  logic                       accept;
  logic                       res_valid;
  trd_pkg::result_t           res;
  trd_pkg::result_t           out_data;

  // Payload length limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= trd_pkg::MaxLenReset;
    end else if (cfg_wr_en_i) begin
      max_len_q <= cfg_wr_data_i;
    end
  end

  // Input register: parser consumes it whenever the skid entry is free.
  assign step       = in_valid_q && !buf_full;
  assign in_stall_o = in_valid_q && buf_full;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept || step) begin
      in_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_byte_q <= log_byte_i;
      in_eol_q  <= end_of_log_i;
    end
  end

  trd_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (step),
    .log_byte_i   (in_byte_q),
    .end_of_log_i (in_eol_q),
    .max_len_i    (max_len_q),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  trd_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data),
    .full_o      (buf_full)
  );

  assign event_kind_o     = out_data.kind;
  assign payload_byte_o   = out_data.payload_byte;
  assign timestamp_ms_o   = out_data.timestamp_ms;
  assign record_length_o  = out_data.record_length;
  assign last_of_record_o = out_data.last_of_record;

  `TRD_ASSERT(a_stall_needs_item, in_stall_o |-> in_valid_q, "input stalled with empty input register")
  `TRD_ASSERT(a_hold_when_stalled, (in_valid_q && buf_full) |=> in_valid_q, "held item dropped")
  `TRD_ASSERT(a_no_step_full, step |-> !buf_full, "parser stepped into a full buffer")

endmodule
